/* hw/rtl/ioeu_pkg.sv */
// ioeu_pkg: command codes, flag positions and stream item layouts for the
// undocumented-opcode execute unit. Used by the top level and its checker.
// No dependencies.

package ioeu_pkg;

	// command codes carried in the cmd field
	typedef enum logic [4:0] {
		CMD_SAX = 5'd0,
		CMD_ANC = 5'd1,
		CMD_ARR = 5'd2,
		CMD_ASR = 5'd3,
		CMD_ATX = 5'd4,
		CMD_AXA = 5'd5,
		CMD_DCP = 5'd6,
		CMD_ISC = 5'd7,
		CMD_LAS = 5'd8,
		CMD_LAX = 5'd9,
		CMD_RLA = 5'd10,
		CMD_RRA = 5'd11,
		CMD_SLO = 5'd12,
		CMD_SRE = 5'd13,
		CMD_SXA = 5'd14,
		CMD_SYA = 5'd15,
		CMD_TAS = 5'd16,
		CMD_XAA = 5'd17
	} cmd_t;

	// bit positions in the flags nibble
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_V = 2;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_C = 0;

	// stream widths, whole bytes
	localparam int unsigned IN_W  = 72;
	localparam int unsigned OUT_W = 64;

	// configuration register indexes
	localparam logic REG_MAGIC = 1'b0;

	// input item, last declared field (cmd) in the lowest bits
	typedef struct packed {
		logic [6:0]  pad;
		logic [3:0]  flags_in;
		logic [7:0]  sp_in;
		logic [7:0]  y_in;
		logic [7:0]  x_in;
		logic [7:0]  acc_in;
		logic [15:0] address;
		logic [7:0]  operand;
		logic [4:0]  cmd;
	} in_item_t;

	// result item, last declared field (acc_out) in the lowest bits
	typedef struct packed {
		logic [9:0]  pad;
		logic        extra_cycle_ok;
		logic [7:0]  mem_data;
		logic [15:0] mem_address;
		logic        mem_write;
		logic [3:0]  flags_out;
		logic [7:0]  sp_out;
		logic [7:0]  x_out;
		logic [7:0]  acc_out;
	} out_item_t;

endpackage

/* hw/rtl/illegal_opcode_execute_unit_top.sv */
// illegal_opcode_execute_unit_top: execute stage for the undocumented opcodes,
// input register, byte ALU and result register. Depends on ioeu_pkg.
//
//  channel | dir | handshake                 | payload
//  s_axis  | in  | s_axis_tvalid/tready      | s_axis_tdata, 72 bits, one instruction
//  m_axis  | out | m_axis_tvalid/tready      | m_axis_tdata, 64 bits, one result
//  apb     | in  | psel/penable/pwrite/pready| paddr, pwdata, prdata, magic constant
//
// one instruction per cycle sustained while m_axis is not stalled; each result moves
// through the input register, then the result register behind the single adder and flag logic
// reset clears both stage valids and the magic constant
// a stall on m_axis holds the result register and backs up into the input register;
// s_axis_tready stays high while either stage can move

module illegal_opcode_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	// cmd, operand, address, acc_in, x_in, y_in, sp_in, flags_in, zero pad
	input  logic [71:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// acc_out, x_out, sp_out, flags_out, mem_write, mem_address, mem_data,
	// extra_cycle_ok, zero pad
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ioeu_pkg::in_item_t  item_s1;
	logic                valid_s1;
	ioeu_pkg::out_item_t res_s2;
	logic                valid_s2;
	logic [7:0]          magic_q;
	logic                ld_s2;
	logic                ld_s1;
	ioeu_pkg::out_item_t res_d;

	// alu signals
	logic [7:0] hi1;
	logic [7:0] inc_m;
	logic [7:0] dec_m;
	logic [7:0] rol_m;
	logic [7:0] ror_m;
	logic [7:0] add_b;
	logic       add_c;
	logic [8:0] sum;
	logic [7:0] acc_n;
	logic [7:0] x_n;
	logic [7:0] sp_n;
	logic       n_f, v_f, z_f, c_f;
	logic       wr;
	logic [7:0] data;
	logic       extra;
	logic [7:0] t;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ioeu_pkg::REG_MAGIC) ? {24'd0, magic_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == ioeu_pkg::REG_MAGIC) begin
			magic_q <= pwdata[7:0];
		end
	end

	// stage handshake
	assign ld_s2         = !valid_s2 || m_axis_tready;
	assign ld_s1         = !valid_s1 || ld_s2;
	assign s_axis_tready = ld_s1;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && s_axis_tvalid) begin
			item_s1 <= ioeu_pkg::in_item_t'(s_axis_tdata);
		end
	end

	// shared operand forms
	assign hi1   = item_s1.address[15:8] + 8'd1;
	assign inc_m = item_s1.operand + 8'd1;
	assign dec_m = item_s1.operand - 8'd1;
	assign rol_m = {item_s1.operand[6:0], item_s1.flags_in[ioeu_pkg::FLAG_C]};
	assign ror_m = {item_s1.flags_in[ioeu_pkg::FLAG_C], item_s1.operand[7:1]};

	// single adder: isc and rra add, dcp compares by subtracting
	always_comb begin
		unique case (item_s1.cmd)
			ioeu_pkg::CMD_ISC: begin
				add_b = ~inc_m;
				add_c = item_s1.flags_in[ioeu_pkg::FLAG_C];
			end
			ioeu_pkg::CMD_RRA: begin
				add_b = ror_m;
				add_c = item_s1.operand[0];
			end
			default: begin
				add_b = ~dec_m;
				add_c = 1'b1;
			end
		endcase
	end

	assign sum = {1'b0, item_s1.acc_in} + {1'b0, add_b} + {8'd0, add_c};

	// opcode logic
	always_comb begin
		acc_n = item_s1.acc_in;
		x_n   = item_s1.x_in;
		sp_n  = item_s1.sp_in;
		n_f   = item_s1.flags_in[ioeu_pkg::FLAG_N];
		v_f   = item_s1.flags_in[ioeu_pkg::FLAG_V];
		z_f   = item_s1.flags_in[ioeu_pkg::FLAG_Z];
		c_f   = item_s1.flags_in[ioeu_pkg::FLAG_C];
		wr    = 1'b0;
		data  = 8'd0;
		extra = 1'b0;
		t     = item_s1.acc_in & item_s1.operand;
		unique case (item_s1.cmd)
			ioeu_pkg::CMD_SAX: begin
				wr   = 1'b1;
				data = item_s1.acc_in & item_s1.x_in;
			end
			ioeu_pkg::CMD_ANC: begin
				acc_n = t;
				c_f   = t[7];
			end
			ioeu_pkg::CMD_ARR: begin
				acc_n = {item_s1.flags_in[ioeu_pkg::FLAG_C], t[7:1]};
				c_f   = acc_n[6];
				v_f   = acc_n[6] ^ acc_n[5];
			end
			ioeu_pkg::CMD_ASR: begin
				c_f   = t[0];
				acc_n = {1'b0, t[7:1]};
			end
			ioeu_pkg::CMD_ATX: begin
				acc_n = (item_s1.acc_in | magic_q) & item_s1.operand;
				x_n   = acc_n;
			end
			ioeu_pkg::CMD_AXA: begin
				wr   = 1'b1;
				data = item_s1.acc_in & item_s1.x_in & hi1;
			end
			ioeu_pkg::CMD_DCP: begin
				wr   = 1'b1;
				data = dec_m;
				c_f  = sum[8];
			end
			ioeu_pkg::CMD_ISC: begin
				wr    = 1'b1;
				data  = inc_m;
				acc_n = sum[7:0];
				c_f   = sum[8];
				v_f   = ~(item_s1.acc_in[7] ^ add_b[7]) & (item_s1.acc_in[7] ^ sum[7]);
			end
			ioeu_pkg::CMD_LAS: begin
				acc_n = item_s1.operand & item_s1.sp_in;
				x_n   = acc_n;
				sp_n  = acc_n;
			end
			ioeu_pkg::CMD_LAX: begin
				acc_n = item_s1.operand;
				x_n   = item_s1.operand;
				extra = 1'b1;
			end
			ioeu_pkg::CMD_RLA: begin
				wr    = 1'b1;
				data  = rol_m;
				c_f   = item_s1.operand[7];
				acc_n = item_s1.acc_in & rol_m;
			end
			ioeu_pkg::CMD_RRA: begin
				wr    = 1'b1;
				data  = ror_m;
				acc_n = sum[7:0];
				c_f   = sum[8];
				v_f   = ~(item_s1.acc_in[7] ^ add_b[7]) & (item_s1.acc_in[7] ^ sum[7]);
			end
			ioeu_pkg::CMD_SLO: begin
				wr    = 1'b1;
				data  = {item_s1.operand[6:0], 1'b0};
				c_f   = item_s1.operand[7];
				acc_n = item_s1.acc_in | {item_s1.operand[6:0], 1'b0};
			end
			ioeu_pkg::CMD_SRE: begin
				wr    = 1'b1;
				data  = {1'b0, item_s1.operand[7:1]};
				c_f   = item_s1.operand[0];
				acc_n = item_s1.acc_in ^ {1'b0, item_s1.operand[7:1]};
			end
			ioeu_pkg::CMD_SXA: begin
				wr   = 1'b1;
				data = item_s1.x_in & hi1;
			end
			ioeu_pkg::CMD_SYA: begin
				wr   = 1'b1;
				data = item_s1.y_in & hi1;
			end
			ioeu_pkg::CMD_TAS: begin
				sp_n = item_s1.acc_in & item_s1.x_in;
				wr   = 1'b1;
				data = item_s1.acc_in & item_s1.x_in & hi1;
			end
			ioeu_pkg::CMD_XAA: begin
				acc_n = (item_s1.acc_in | magic_q) & item_s1.x_in & item_s1.operand;
			end
			default: begin
				// unused codes pass everything through
			end
		endcase

		// n and z follow the new accumulator value, or the compare difference for dcp
		unique case (item_s1.cmd)
			ioeu_pkg::CMD_ANC, ioeu_pkg::CMD_ARR, ioeu_pkg::CMD_ASR, ioeu_pkg::CMD_ATX,
			ioeu_pkg::CMD_ISC, ioeu_pkg::CMD_LAS, ioeu_pkg::CMD_LAX, ioeu_pkg::CMD_RLA,
			ioeu_pkg::CMD_RRA, ioeu_pkg::CMD_SLO, ioeu_pkg::CMD_SRE,
			ioeu_pkg::CMD_XAA: begin
				n_f = acc_n[7];
				z_f = (acc_n == 8'd0);
			end
			ioeu_pkg::CMD_DCP: begin
				n_f = sum[7];
				z_f = (sum[7:0] == 8'd0);
			end
			default: begin
				// flags untouched
			end
		endcase
	end

	// result assembly
	always_comb begin
		res_d                = '0;
		res_d.acc_out        = acc_n;
		res_d.x_out          = x_n;
		res_d.sp_out         = sp_n;
		res_d.flags_out      = {n_f, v_f, z_f, c_f};
		res_d.mem_write      = wr;
		res_d.mem_address    = wr ? item_s1.address : 16'd0;
		res_d.mem_data       = wr ? data : 8'd0;
		res_d.extra_cycle_ok = extra;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ld_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

/* hw/rtl/ioeu_checker.sv */
// ioeu_checker: port-level assertions for the execute unit, bound to the top level.
// Depends on ioeu_pkg and illegal_opcode_execute_unit_top.

module ioeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	ioeu_pkg::out_item_t res;
	assign res = ioeu_pkg::out_item_t'(m_axis_tdata);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// no write means zero address and data
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.mem_write |-> res.mem_address == 16'd0 && res.mem_data == 8'd0)
		else $error("write fields set without a write");

	// the penalty bit belongs to lax, which never writes
	a_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.extra_cycle_ok |-> !res.mem_write)
		else $error("penalty bit on a writing opcode");

	// nothing offered while in reset, pad bits stay clear
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result offered in reset");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.pad == 10'd0)
		else $error("pad bits set");

endmodule

bind illegal_opcode_execute_unit_top ioeu_checker u_ioeu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

/* bench/ioeu_checker.sv */
// ioeu_bench_checker: watches both stream channels and the register port of the
// undocumented-opcode execute unit, predicts every result and compares it.
// Depends on ioeu_pkg.

module ioeu_bench_checker
	import ioeu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [71:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int unsigned fail_count,
	output int unsigned in_flight
);

	localparam logic [2:0] MAGIC_ADDR = {REG_MAGIC, 2'b00};

	logic [7:0]  magic_value;
	out_item_t   pending_results[$];
	int unsigned errors = 0;

	// n and z from a byte, other flags kept
	function automatic logic [3:0] with_nz(input logic [3:0] fl, input logic [7:0] v);
		fl[FLAG_N] = v[7];
		fl[FLAG_Z] = (v == 8'h00);
		return fl;
	endfunction

	// flags of a binary add with carry in
	function automatic logic [3:0] adc_flags(input logic [3:0] fl, input logic [7:0] p,
			input logic [7:0] q, input logic ci);
		logic [8:0] total;
		total = {1'b0, p} + {1'b0, q} + {8'h00, ci};
		fl[FLAG_C] = total[8];
		fl[FLAG_V] = ~(p[7] ^ q[7]) & (p[7] ^ total[7]);
		return with_nz(fl, total[7:0]);
	endfunction

	// one instruction through the execute stage
	function automatic out_item_t execute_instr(input in_item_t ins, input logic [7:0] mc);
		out_item_t  r;
		logic [7:0] a, x, s, m, t, q, hi1, data;
		logic [3:0] f;
		logic       cin, wr, extra;
		a = ins.acc_in;
		x = ins.x_in;
		s = ins.sp_in;
		m = ins.operand;
		f = ins.flags_in;
		cin = f[FLAG_C];
		hi1 = ins.address[15:8] + 8'd1;
		wr = 1'b0;
		data = 8'h00;
		extra = 1'b0;
		case (ins.cmd)
			CMD_SAX: begin
				wr = 1'b1;
				data = a & x;
			end
			CMD_ANC: begin
				a = a & m;
				f = with_nz(f, a);
				f[FLAG_C] = a[7];
			end
			CMD_ARR: begin
				t = a & m;
				a = {cin, t[7:1]};
				f = with_nz(f, a);
				f[FLAG_C] = a[6];
				f[FLAG_V] = a[6] ^ a[5];
			end
			CMD_ASR: begin
				t = a & m;
				f[FLAG_C] = t[0];
				a = {1'b0, t[7:1]};
				f = with_nz(f, a);
			end
			CMD_ATX: begin
				a = (a | mc) & m;
				x = a;
				f = with_nz(f, a);
			end
			CMD_AXA: begin
				wr = 1'b1;
				data = a & x & hi1;
			end
			CMD_DCP: begin
				t = m - 8'd1;
				wr = 1'b1;
				data = t;
				f[FLAG_C] = (a >= t);
				f = with_nz(f, a - t);
			end
			CMD_ISC: begin
				t = m + 8'd1;
				q = ~t;
				wr = 1'b1;
				data = t;
				f = adc_flags(f, a, q, cin);
				a = a + q + {7'd0, cin};
			end
			CMD_LAS: begin
				t = m & s;
				a = t;
				x = t;
				s = t;
				f = with_nz(f, t);
			end
			CMD_LAX: begin
				a = m;
				x = m;
				f = with_nz(f, m);
				extra = 1'b1;
			end
			CMD_RLA: begin
				t = {m[6:0], cin};
				wr = 1'b1;
				data = t;
				f[FLAG_C] = m[7];
				a = a & t;
				f = with_nz(f, a);
			end
			CMD_RRA: begin
				t = {cin, m[7:1]};
				wr = 1'b1;
				data = t;
				f = adc_flags(f, a, t, m[0]);
				a = a + t + {7'd0, m[0]};
			end
			CMD_SLO: begin
				t = {m[6:0], 1'b0};
				wr = 1'b1;
				data = t;
				f[FLAG_C] = m[7];
				a = a | t;
				f = with_nz(f, a);
			end
			CMD_SRE: begin
				t = {1'b0, m[7:1]};
				wr = 1'b1;
				data = t;
				f[FLAG_C] = m[0];
				a = a ^ t;
				f = with_nz(f, a);
			end
			CMD_SXA: begin
				wr = 1'b1;
				data = x & hi1;
			end
			CMD_SYA: begin
				wr = 1'b1;
				data = ins.y_in & hi1;
			end
			CMD_TAS: begin
				s = a & x;
				wr = 1'b1;
				data = s & hi1;
			end
			CMD_XAA: begin
				a = (a | mc) & x & m;
				f = with_nz(f, a);
			end
			default: begin
			end
		endcase
		r = '0;
		r.acc_out = a;
		r.x_out = x;
		r.sp_out = s;
		r.flags_out = f;
		r.mem_write = wr;
		r.mem_address = wr ? ins.address : 16'h0000;
		r.mem_data = wr ? data : 8'h00;
		r.extra_cycle_ok = extra;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// sample every transfer at the rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want, got;
		if (!arst_n) begin
			magic_value = 8'h00;
			fail_count <= 0;
			in_flight <= 0;
		end else begin
			// register port: writes update the copy, reads are checked
			if (psel && penable && pready && paddr == MAGIC_ADDR) begin
				if (pwrite)
					magic_value = pwdata[7:0];
				else
					compare_field("magic readback", {24'h0, magic_value}, prdata);
			end
			// result transfer against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", m_axis_tdata);
				end else begin
					want = pending_results.pop_front();
					compare_field("acc_out", 32'(want.acc_out), 32'(got.acc_out));
					compare_field("x_out", 32'(want.x_out), 32'(got.x_out));
					compare_field("sp_out", 32'(want.sp_out), 32'(got.sp_out));
					compare_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
					compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
					compare_field("mem_address", 32'(want.mem_address),
						32'(got.mem_address));
					compare_field("mem_data", 32'(want.mem_data), 32'(got.mem_data));
					compare_field("extra_cycle_ok", 32'(want.extra_cycle_ok),
						32'(got.extra_cycle_ok));
				end
			end
			// instruction transfer
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(execute_instr(s_axis_tdata, magic_value));
			fail_count <= errors;
			in_flight <= pending_results.size();
		end
	end

endmodule

/* bench/tb_illegal_opcode_execute_unit_top.sv */
// tb_illegal_opcode_execute_unit_top: clock, reset, instruction stimulus,
// result back-pressure and register writes for the execute unit, with the
// verdict. Depends on ioeu_pkg, ioeu_bench_checker and the unit's top level.

module tb_illegal_opcode_execute_unit_top;
	import ioeu_pkg::*;

	localparam logic [2:0] MAGIC_ADDR = {REG_MAGIC, 2'b00};
	// slot after the last register, writes there are dropped
	localparam logic [2:0] SPARE_ADDR = MAGIC_ADDR + 3'd4;
	localparam logic [4:0] CMD_UNUSED_LO = CMD_XAA + 5'd1;
	localparam logic [4:0] CMD_UNUSED_HI = 5'h1f;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 310;

	logic        clk;
	logic        arst_n;
	logic [71:0] s_axis_tdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int unsigned fail_count;
	int unsigned in_flight;
	logic        tx_quiet;
	logic        rx_quiet;

	illegal_opcode_execute_unit_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	ioeu_bench_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.in_flight     (in_flight)
	);

	// clock, period 2
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#800000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stall after each transfer
	initial begin : result_sink
		int unsigned stall;
		m_axis_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				stall = rx_quiet ? 0 : $urandom_range(0, 13);
				if (stall != 0) begin
					@(negedge clk) m_axis_tready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
					@(negedge clk) m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// one instruction transfer after a random gap
	task automatic send_instr(input in_item_t it);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tdata <= it;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_fields(input logic [4:0] c, input logic [7:0] m,
			input logic [15:0] addr, input logic [7:0] a, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] s, input logic [3:0] f);
		in_item_t it;
		it = '0;
		it.cmd = c;
		it.operand = m;
		it.address = addr;
		it.acc_in = a;
		it.x_in = x;
		it.y_in = y;
		it.sp_in = s;
		it.flags_in = f;
		send_instr(it);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// bytes leaning towards the corner values
	function automatic logic [7:0] skewed_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			4: return 8'h01;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic in_item_t random_instr();
		in_item_t it;
		it = '0;
		if ($urandom_range(0, 11) == 0)
			it.cmd = 5'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		else
			it.cmd = 5'($urandom_range(CMD_SAX, CMD_XAA));
		it.operand = skewed_byte();
		// high byte of all ones makes the store mask wrap to zero
		it.address[15:8] = ($urandom_range(0, 7) == 0) ? 8'hff : skewed_byte();
		it.address[7:0] = 8'($urandom_range(0, 255));
		it.acc_in = skewed_byte();
		it.x_in = skewed_byte();
		it.y_in = skewed_byte();
		it.sp_in = skewed_byte();
		it.flags_in = 4'($urandom_range(0, 15));
		return it;
	endfunction

	initial begin : stimulus
		logic [7:0] setting;
		s_axis_tdata = '0;
		s_axis_tvalid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		apb_access(1'b0, MAGIC_ADDR, '0);

		// directed part, magic constant at its reset value
		send_fields(CMD_SAX, 8'h00, 16'hffff, 8'hff, 8'h0f, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_ANC, 8'h80, 16'h0000, 8'hff, 8'h00, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_ARR, 8'hff, 16'h1234, 8'hff, 8'h00, 8'h00, 8'h00, 4'h1);
		send_fields(CMD_ARR, 8'hff, 16'h1234, 8'h80, 8'h00, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_ASR, 8'hff, 16'h0000, 8'h01, 8'h00, 8'h00, 8'h00, 4'h8);
		send_fields(CMD_ATX, 8'hf0, 16'h0000, 8'h3c, 8'h00, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_AXA, 8'h00, 16'hff00, 8'hff, 8'hff, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_DCP, 8'h00, 16'h8001, 8'h00, 8'h00, 8'h00, 8'h00, 4'hf);
		send_fields(CMD_ISC, 8'hff, 16'h4000, 8'h80, 8'h00, 8'h00, 8'h00, 4'h1);
		send_fields(CMD_ISC, 8'h00, 16'h4000, 8'h7f, 8'h00, 8'h00, 8'h00, 4'h1);
		send_fields(CMD_LAS, 8'hf5, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h5f, 4'h0);
		send_fields(CMD_LAX, 8'h00, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff, 4'hf);
		send_fields(CMD_RLA, 8'h80, 16'hfffe, 8'hff, 8'h00, 8'h00, 8'h00, 4'h1);
		send_fields(CMD_RRA, 8'h01, 16'h0001, 8'h7f, 8'h00, 8'h00, 8'h00, 4'h1);
		send_fields(CMD_SLO, 8'h80, 16'h00ff, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_SRE, 8'h01, 16'h8000, 8'h80, 8'h00, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_SXA, 8'h00, 16'h7fff, 8'h00, 8'hff, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_SYA, 8'h00, 16'hfe12, 8'h00, 8'h00, 8'hff, 8'h00, 4'h0);
		send_fields(CMD_TAS, 8'h00, 16'hffab, 8'hff, 8'hff, 8'h00, 8'h00, 4'h0);
		send_fields(CMD_XAA, 8'hff, 16'h0000, 8'h0f, 8'hff, 8'h00, 8'h00, 4'hf);
		send_fields(CMD_UNUSED_LO, 8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 4'hf);
		send_fields(CMD_UNUSED_HI, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0);

		// random phases, each with its own magic constant and idling mix
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: setting = 8'hff;
				1: setting = 8'h00;
				default: setting = 8'($urandom_range(0, 255));
			endcase
			apb_access(1'b1, MAGIC_ADDR,
				{8'($urandom_range(0, 255)), 16'h0000, setting});
			if (ph == 2)
				apb_access(1'b1, SPARE_ADDR, '1);
			apb_access(1'b0, MAGIC_ADDR, '0);
			tx_quiet = (ph == 1) || (ph == 4);
			rx_quiet = (ph == 1) || (ph == 3);
			for (int unsigned n = 0; n < PHASE_ITEMS; n++)
				send_instr(random_instr());
		end

		drain();
		if (fail_count == 0 && in_flight == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* illegal_opcode_execute_unit_top.f */
hw/rtl/ioeu_pkg.sv
hw/rtl/illegal_opcode_execute_unit_top.sv
hw/rtl/ioeu_checker.sv
bench/ioeu_checker.sv
bench/tb_illegal_opcode_execute_unit_top.sv
